FILE: design/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

    // Component width and the widths that follow from it.
    localparam int COMP_BITS  = 8;
    localparam int HUE_W      = 13;
    // Quotient bits: the hue quotient reaches 960, the saturation quotient reaches FULL.
    localparam int QUO_BITS   = (COMP_BITS > 10) ? COMP_BITS : 10;
    localparam int NUM_W      = QUO_BITS + COMP_BITS;
    localparam int DIFF_W     = COMP_BITS + 1;
    localparam int HSUM_W     = HUE_W + 1;

    localparam logic [COMP_BITS-1:0] COMP_FULL = {COMP_BITS{1'b1}};
    localparam logic [HUE_W-1:0]     HUE_SECTOR = HUE_W'(960);
    localparam logic [HUE_W-1:0]     HUE_FULL   = HUE_W'(5760);

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [COMP_BITS-1:0] red;
        logic [COMP_BITS-1:0] green;
        logic [COMP_BITS-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]     hue;
        logic [COMP_BITS-1:0] saturation;
        logic [COMP_BITS-1:0] brightness;
    } hsv_t;

    // Result of the max/min sort.
    typedef struct packed {
        logic [COMP_BITS-1:0] mx;
        logic [COMP_BITS-1:0] delta;
        logic [COMP_BITS-1:0] mag;
        logic                 neg;
        sector_t              sector;
        logic                 gray;
    } sort_t;

    // One lane of the restoring divider: partial remainder, dividend bits
    // still to shift in (with quotient bits filling from the bottom), divisor.
    typedef struct packed {
        logic [COMP_BITS-1:0] rem;
        logic [QUO_BITS-1:0]  bits;
        logic [COMP_BITS-1:0] dvs;
    } lane_t;

    typedef struct packed {
        logic [COMP_BITS-1:0] brightness;
        logic [HUE_W-1:0]     base;
        logic                 neg;
        logic                 gray;
    } side_t;

    typedef struct packed {
        lane_t sat;
        lane_t hue;
        side_t side;
    } div_item_t;

    // One restoring division step: shift in the next dividend bit and
    // subtract the divisor when it fits.
    function automatic lane_t div_step(input lane_t lane);
        logic [COMP_BITS:0] trial;
        logic [COMP_BITS:0] dvs_ext;
        logic               qbit;
        lane_t              res;
        trial   = {lane.rem, lane.bits[QUO_BITS-1]};
        dvs_ext = {1'b0, lane.dvs};
        qbit    = (trial >= dvs_ext);
        res     = lane;
        if (qbit)
        begin
            res.rem = COMP_BITS'(trial - dvs_ext);
        end
        else
        begin
            res.rem = trial[COMP_BITS-1:0];
        end
        res.bits = {lane.bits[QUO_BITS-2:0], qbit};
        return res;
    endfunction

endpackage

FILE: design/rgb_to_hsv_converter_top.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// pixel     pix_valid/pix_ready    pix : pixel_t (red, green, blue)
// result    hsv_valid/hsv_ready    hsv : hsv_t (hue, saturation, brightness)
//
// One pixel per cycle sustained while the result side is ready; the restoring divider
// resolves one quotient bit per stage for saturation and hue in parallel.
// Reset clears all stage valid bits; no clearing pass is needed.
// A stall holds each full stage; empty stages upstream keep filling.

module rgb_to_hsv_converter_top
    import rhc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pix_valid,
    output logic   pix_ready,
    input  pixel_t pix,
    output logic   hsv_valid,
    input  logic   hsv_ready,
    output hsv_t   hsv
);

    logic      stg_valid [QUO_BITS+1];
    logic      stg_ready [QUO_BITS+1];
    div_item_t stg_item  [QUO_BITS+1];

    // Sort and dividend setup.
    rhc_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pix_valid),
        .up_ready (pix_ready),
        .up_item  (pix),
        .dn_valid (stg_valid[0]),
        .dn_ready (stg_ready[0]),
        .dn_item  (stg_item[0])
    );

    // Divider pipeline, one quotient bit per stage.
    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_div
        rhc_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[i]),
            .up_ready (stg_ready[i]),
            .up_item  (stg_item[i]),
            .dn_valid (stg_valid[i+1]),
            .dn_ready (stg_ready[i+1]),
            .dn_item  (stg_item[i+1])
        );
    end

    // Hue assembly and output register.
    rhc_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stg_valid[QUO_BITS]),
        .up_ready (stg_ready[QUO_BITS]),
        .up_item  (stg_item[QUO_BITS]),
        .dn_valid (hsv_valid),
        .dn_ready (hsv_ready),
        .dn_item  (hsv)
    );

endmodule

FILE: design/rhc_prep.sv
`timescale 1ns / 1ps

module rhc_prep
    import rhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  pixel_t    up_item,
    output logic      dn_valid,
    input  logic      dn_ready,
    output div_item_t dn_item
);

    logic      sort_valid_reg;
    sort_t     sort_reg;
    sort_t     sort_next;
    logic      sort_ready;
    logic      num_valid_reg;
    div_item_t num_reg;
    div_item_t num_next;

    logic [COMP_BITS-1:0] r;
    logic [COMP_BITS-1:0] g;
    logic [COMP_BITS-1:0] b;
    logic [COMP_BITS-1:0] mx;
    logic [COMP_BITS-1:0] mn;
    sector_t              sec;
    logic [DIFF_W-1:0]    diff;
    logic [NUM_W-1:0]     sat_num;
    logic [NUM_W-1:0]     hue_num;

    assign r = up_item.red;
    assign g = up_item.green;
    assign b = up_item.blue;

    // Sort the components; ties pick the sector in a fixed order.
    always_comb
    begin
        if (r > g)
        begin
            mx  = r;
            sec = SEC_RED;
            if (b < g)
            begin
                mn = b;
            end
            else
            begin
                mn = g;
                if (b > r)
                begin
                    mx  = b;
                    sec = SEC_BLUE;
                end
            end
        end
        else
        begin
            mn = r;
            if (b > g)
            begin
                mx  = b;
                sec = SEC_BLUE;
            end
            else
            begin
                mx  = g;
                sec = SEC_GREEN;
                if (b < r)
                begin
                    mn = b;
                end
            end
        end
    end

    // Signed difference of the two components that are not the maximum.
    always_comb
    begin
        case (sec)
            SEC_RED:  diff = {1'b0, g} - {1'b0, b};
            SEC_BLUE: diff = {1'b0, r} - {1'b0, g};
            default:  diff = {1'b0, b} - {1'b0, r};
        endcase
    end

    always_comb
    begin
        sort_next.mx     = mx;
        sort_next.delta  = mx - mn;
        sort_next.neg    = diff[DIFF_W-1];
        sort_next.mag    = diff[DIFF_W-1] ? COMP_BITS'(-diff) : diff[COMP_BITS-1:0];
        sort_next.sector = sec;
        sort_next.gray   = (mx == '0) || (mx == mn);
    end

    // Form both dividends and load the divider lanes.
    always_comb
    begin
        sat_num = NUM_W'(sort_reg.delta) * NUM_W'(COMP_FULL);
        hue_num = NUM_W'(sort_reg.mag) * NUM_W'(HUE_SECTOR);

        num_next.sat.rem  = sat_num[NUM_W-1:QUO_BITS];
        num_next.sat.bits = sat_num[QUO_BITS-1:0];
        num_next.sat.dvs  = sort_reg.mx;
        num_next.hue.rem  = hue_num[NUM_W-1:QUO_BITS];
        num_next.hue.bits = hue_num[QUO_BITS-1:0];
        num_next.hue.dvs  = sort_reg.delta;

        num_next.side.brightness = sort_reg.mx;
        num_next.side.neg        = sort_reg.neg;
        num_next.side.gray       = sort_reg.gray;
        case (sort_reg.sector)
            SEC_RED:  num_next.side.base = '0;
            SEC_BLUE: num_next.side.base = HUE_W'({HUE_SECTOR, 2'b00});
            default:  num_next.side.base = HUE_W'({HUE_SECTOR, 1'b0});
        endcase
    end

    // A stage takes a new item when empty or when its item moves on.
    assign sort_ready = !num_valid_reg || dn_ready;
    assign up_ready   = !sort_valid_reg || sort_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_valid_reg <= 1'b0;
            num_valid_reg  <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                sort_valid_reg <= up_valid;
            end
            if (sort_ready)
            begin
                num_valid_reg <= sort_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            sort_reg <= sort_next;
        end
        if (sort_ready && sort_valid_reg)
        begin
            num_reg <= num_next;
        end
    end

    assign dn_valid = num_valid_reg;
    assign dn_item  = num_reg;

endmodule

FILE: design/rhc_div_stage.sv
`timescale 1ns / 1ps

module rhc_div_stage
    import rhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  div_item_t up_item,
    output logic      dn_valid,
    input  logic      dn_ready,
    output div_item_t dn_item
);

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;

    // One quotient bit for each lane.
    always_comb
    begin
        item_next      = up_item;
        item_next.sat  = div_step(up_item.sat);
        item_next.hue  = div_step(up_item.hue);
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

FILE: design/rhc_post.sv
`timescale 1ns / 1ps

module rhc_post
    import rhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  div_item_t up_item,
    output logic      dn_valid,
    input  logic      dn_ready,
    output hsv_t      dn_item
);

    logic              valid_reg;
    hsv_t              hsv_reg;
    hsv_t              hsv_next;
    logic [HSUM_W-1:0] mag;
    logic [HSUM_W-1:0] sum;

    // Floor of a negative quotient rounds its magnitude up when a remainder is left.
    always_comb
    begin
        mag = HSUM_W'(up_item.hue.bits)
            + HSUM_W'(up_item.side.neg && (up_item.hue.rem != '0));
        if (up_item.side.neg)
        begin
            sum = HSUM_W'(up_item.side.base) - mag;
        end
        else
        begin
            sum = HSUM_W'(up_item.side.base) + mag;
        end
        // Wrap into one turn of the hue circle.
        if (sum[HSUM_W-1])
        begin
            sum = sum + HSUM_W'(HUE_FULL);
        end
        else if (sum >= HSUM_W'(HUE_FULL))
        begin
            sum = sum - HSUM_W'(HUE_FULL);
        end

        hsv_next.brightness = up_item.side.brightness;
        if (up_item.side.gray)
        begin
            hsv_next.hue        = '0;
            hsv_next.saturation = '0;
        end
        else
        begin
            hsv_next.hue        = sum[HUE_W-1:0];
            hsv_next.saturation = up_item.sat.bits[COMP_BITS-1:0];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            hsv_reg <= hsv_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = hsv_reg;

endmodule

FILE: tb/sv/rgb_to_hsv_converter_top_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top_tb;
    import rhc_pkg::*;

    localparam int RAND_ITEMS  = 966;
    localparam int STEADY_RUN  = 300;
    localparam int BURST_ITEMS = 60;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_WAIT  = 40;
    localparam int DIR_N       = 24;

    // One stimulus row: the pixel and, where it is obvious, its typed result.
    typedef struct packed {
        logic   known;
        pixel_t pix;
        hsv_t   want;
    } pixel_row_t;

    logic   clk;
    logic   rst_n     = 1'b0;
    logic   pix_valid = 1'b0;
    logic   pix_ready;
    pixel_t pix       = '0;
    logic   hsv_valid;
    logic   hsv_ready = 1'b0;
    hsv_t   hsv;

    pixel_row_t pending_q[$];
    hsv_t       hsv_q[$];
    pixel_row_t dir_rows[DIR_N];

    int n_offered  = 0;
    int n_checked  = 0;
    int fail_count = 0;
    bit quiet      = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    rgb_to_hsv_converter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv)
    );

    // Hue, saturation and value of one pixel, following the sector rules.
    function automatic hsv_t hsv_of(input pixel_t p);
        int      r;
        int      g;
        int      b;
        int      top;
        int      bottom;
        int      span;
        int      base;
        int      diff;
        int      num;
        int      quot;
        int      h;
        sector_t sec;
        hsv_t    o;
        r = p.red;
        g = p.green;
        b = p.blue;
        if (r > g)
        begin
            top    = r;
            sec    = SEC_RED;
            bottom = (b < g) ? b : g;
            if (b >= g && b > r)
            begin
                top = b;
                sec = SEC_BLUE;
            end
        end
        else
        begin
            bottom = r;
            if (b > g)
            begin
                top = b;
                sec = SEC_BLUE;
            end
            else
            begin
                top = g;
                sec = SEC_GREEN;
                if (b < r)
                begin
                    bottom = b;
                end
            end
        end
        span         = top - bottom;
        o.brightness = COMP_BITS'(top);
        if (top == 0 || span == 0)
        begin
            o.hue        = '0;
            o.saturation = '0;
            return o;
        end
        o.saturation = COMP_BITS'((span * int'(COMP_FULL)) / top);
        case (sec)
            SEC_RED:
            begin
                base = 0;
                diff = g - b;
            end
            SEC_GREEN:
            begin
                base = 2 * int'(HUE_SECTOR);
                diff = b - r;
            end
            default:
            begin
                base = 4 * int'(HUE_SECTOR);
                diff = r - g;
            end
        endcase
        // Division rounds toward minus infinity.
        num  = diff * int'(HUE_SECTOR);
        quot = num / span;
        if (num < 0 && (num % span) != 0)
        begin
            quot = quot - 1;
        end
        h = base + quot;
        if (h < 0)
        begin
            h = h + int'(HUE_FULL);
        end
        if (h >= int'(HUE_FULL))
        begin
            h = h - int'(HUE_FULL);
        end
        o.hue = HUE_W'(h);
        return o;
    endfunction

    // Random pixel, weighted toward ties, grays and extreme values.
    function automatic pixel_t rand_pixel();
        pixel_t  p;
        int      pick;
        pick = $urandom_range(0, 9);
        p = pixel_t'({$urandom, $urandom});
        case (pick)
            5:
            begin
                p.green = p.red;
            end
            6:
            begin
                p.blue = ($urandom_range(0, 1) == 1) ? p.red : p.green;
            end
            7:
            begin
                p.green = p.red;
                p.blue  = p.red;
            end
            8:
            begin
                p.red   = COMP_BITS'($urandom_range(0, 1) ? COMP_FULL - $urandom_range(0, 1)
                                                           : $urandom_range(0, 1));
                p.green = COMP_BITS'($urandom_range(0, 1) ? COMP_FULL - $urandom_range(0, 1)
                                                           : $urandom_range(0, 1));
                p.blue  = COMP_BITS'($urandom_range(0, 1) ? COMP_FULL - $urandom_range(0, 1)
                                                           : $urandom_range(0, 1));
            end
            9:
            begin
                p.red   = COMP_BITS'($urandom_range(0, 3));
                p.green = COMP_BITS'($urandom_range(0, 3));
                p.blue  = COMP_BITS'($urandom_range(0, 3));
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    // Offer one pixel and hold it until the transfer completes.
    task automatic offer_pixel(input pixel_row_t row, input bit may_idle);
        if (may_idle && !quiet && $urandom_range(0, 99) < 6)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pending_q.push_back(row);
        n_offered++;
        pix       <= row.pix;
        pix_valid <= 1'b1;
        @(posedge clk);
        while (!pix_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        while (n_checked != n_offered)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous overall limit.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, a steady stretch and one long hold-off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hsv_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                hsv_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 6);
            end
        end
    end

    // Record accepted pixels and check each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        pixel_row_t row;
        hsv_t       want;
        if (rst_n && pix_valid && pix_ready)
        begin
            row = pending_q.pop_front();
            hsv_q.push_back(row.known ? row.want : hsv_of(pix));
        end
        if (rst_n && hsv_valid && hsv_ready)
        begin
            n_checked++;
            if (hsv_q.size() == 0)
            begin
                $error("result transfer with no pixel outstanding: %h", hsv);
                fail_count++;
            end
            else
            begin
                want = hsv_q.pop_front();
                if (hsv.hue !== want.hue)
                begin
                    $error("hue mismatch: expected %0d, actual %0d", want.hue, hsv.hue);
                    fail_count++;
                end
                if (hsv.saturation !== want.saturation)
                begin
                    $error("saturation mismatch: expected %0d, actual %0d",
                           want.saturation, hsv.saturation);
                    fail_count++;
                end
                if (hsv.brightness !== want.brightness)
                begin
                    $error("brightness mismatch: expected %0d, actual %0d",
                           want.brightness, hsv.brightness);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        pixel_row_t row;
        // Primaries, secondaries, grays and black have results that can be written down directly.
        dir_rows = '{
            '{1'b1, '{8'd0,   8'd0,   8'd0},   '{13'd0,    8'd0,   8'd0}},
            '{1'b1, '{8'd255, 8'd255, 8'd255}, '{13'd0,    8'd0,   8'd255}},
            '{1'b1, '{8'd128, 8'd128, 8'd128}, '{13'd0,    8'd0,   8'd128}},
            '{1'b1, '{8'd1,   8'd1,   8'd1},   '{13'd0,    8'd0,   8'd1}},
            '{1'b1, '{8'd255, 8'd0,   8'd0},   '{13'd0,    8'd255, 8'd255}},
            '{1'b1, '{8'd0,   8'd255, 8'd0},   '{13'd1920, 8'd255, 8'd255}},
            '{1'b1, '{8'd0,   8'd0,   8'd255}, '{13'd3840, 8'd255, 8'd255}},
            '{1'b1, '{8'd255, 8'd255, 8'd0},   '{13'd960,  8'd255, 8'd255}},
            '{1'b1, '{8'd0,   8'd255, 8'd255}, '{13'd2880, 8'd255, 8'd255}},
            '{1'b1, '{8'd255, 8'd0,   8'd255}, '{13'd4800, 8'd255, 8'd255}},
            '{1'b1, '{8'd1,   8'd0,   8'd0},   '{13'd0,    8'd255, 8'd1}},
            // Hue just below the wrap point, ties for the maximum, mixed values.
            '{1'b0, '{8'd255, 8'd0,   8'd1},   '0},
            '{1'b0, '{8'd255, 8'd1,   8'd0},   '0},
            '{1'b0, '{8'd254, 8'd255, 8'd255}, '0},
            '{1'b0, '{8'd255, 8'd254, 8'd255}, '0},
            '{1'b0, '{8'd255, 8'd255, 8'd254}, '0},
            '{1'b0, '{8'd200, 8'd100, 8'd100}, '0},
            '{1'b0, '{8'd100, 8'd200, 8'd100}, '0},
            '{1'b0, '{8'd100, 8'd100, 8'd200}, '0},
            '{1'b0, '{8'd85,  8'd170, 8'd255}, '0},
            '{1'b0, '{8'd170, 8'd85,  8'd0},   '0},
            '{1'b0, '{8'd1,   8'd2,   8'd3},   '0},
            '{1'b0, '{8'd255, 8'd128, 8'd127}, '0},
            '{1'b0, '{8'd0,   8'd1,   8'd255}, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int i = 0; i < DIR_N; i++)
        begin
            offer_pixel(dir_rows[i], 1'b1);
        end

        // Back-pressure burst: the result side holds off while pixels keep coming.
        hold_req = 1'b1;
        for (int i = 0; i < BURST_ITEMS; i++)
        begin
            row.known = 1'b0;
            row.pix   = rand_pixel();
            row.want  = '0;
            offer_pixel(row, 1'b0);
        end

        // Pause until every outstanding result has come back.
        pix_valid <= 1'b0;
        drain_results();

        // Random pixels: a steady stretch first, then random idling on both sides.
        quiet = 1'b1;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == STEADY_RUN)
            begin
                quiet = 1'b0;
            end
            row.known = 1'b0;
            row.pix   = rand_pixel();
            row.want  = '0;
            offer_pixel(row, 1'b1);
        end
        pix_valid <= 1'b0;

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (hsv_q.size() != 0)
        begin
            $error("%0d results never arrived", hsv_q.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
